>>> rtl/core/rbb_pkg.sv
// Shared types, constants and register codes for the retry backoff budget block.
package rbb_pkg;

  // Retry counter and budget
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] EXTRA_THROTTLE_RETRIES = 9'd5;

  // Wait values
  localparam int unsigned WAIT_W = 63;
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
  localparam int unsigned CLAMP_W = 14;
  localparam logic [CLAMP_W-1:0] THROTTLE_CAP_MS = 14'd10000;
  localparam logic [CLAMP_W-1:0] MS_PER_S = 14'd1000;
  localparam logic [31:0] RA_CAP_S = 32'd10;

  // Jitter remainder unit
  localparam int unsigned JIT_DIV_W = 13;
  localparam int unsigned JIT_DVD_W = 64;
  localparam int unsigned JIT_CNT_W = 7;
  localparam logic [JIT_CNT_W-1:0] JIT_STEPS = 7'd64;

  // Shared multiply-accumulate unit
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_C_W = 49;
  localparam int unsigned MUL_P_W = 50;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_WAIT_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_FACTOR = 2'd2;

  typedef struct packed {
    logic        throttled;
    logic        retry_after_valid;
    logic [31:0] retry_after_seconds;
    logic [63:0] random_word;
  } evt_t;

  typedef struct packed {
    logic              retry_allowed;
    logic [WAIT_W-1:0] wait_ms;
    logic [CNT_W-1:0]  retries_so_far;
  } res_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
    logic [MUL_C_W-1:0] c;
  } mul_op_t;

  typedef struct packed {
    logic                 start;
    logic [JIT_DVD_W-1:0] dividend;
    logic [JIT_DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [JIT_DIV_W-1:0] rem;
  } mod_rsp_t;

endpackage

>>> rtl/core/rbb_mul_unit.sv
// Shared 32x16 multiply-accumulate unit with a registered product.
module rbb_mul_unit
  import rbb_pkg::*;
(
  input  logic               clk,
  input  mul_op_t            op,
  output logic [MUL_P_W-1:0] p
);

  // Register a*b+c every cycle
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(op.a * op.b) + MUL_P_W'(op.c);
  end

endmodule

>>> rtl/core/rbb_mod_unit.sv
// Bit-serial restoring remainder unit for the jitter term.
module rbb_mod_unit
  import rbb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [JIT_CNT_W-1:0] cnt;
  logic [JIT_DVD_W-1:0] dvd;
  logic [JIT_DIV_W-1:0] div_q;
  logic [JIT_DIV_W-1:0] rem;
  logic                 done;
  logic [JIT_DIV_W:0]   trial;

  // Shift the next dividend bit into the partial remainder
  assign trial = {rem, dvd[JIT_DVD_W-1]};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= JIT_STEPS;
      done <= 1'b0;
    end else begin
      done <= (cnt == JIT_CNT_W'(1));
      if (cnt != '0) begin
        cnt <= cnt - JIT_CNT_W'(1);
      end
    end
  end

  // Datapath: one compare and subtract per bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd   <= req.dividend;
      div_q <= req.divisor;
      rem   <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[JIT_DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem <= JIT_DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem <= trial[JIT_DIV_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

>>> rtl/core/retry_backoff_budget.sv
// Top level of the retry budget block: sequencer, state and configuration registers.
//
//   channel | signals                              | beat
//   --------+--------------------------------------+----------------------------------
//   evt     | evt_valid, evt_ready, evt            | one failed-attempt event
//   res     | res_valid, res_ready, res            | one result per event
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write
//
// Each exponent step of the backoff product runs three partial products and an update on
// the shared 32x16 multiplier; a throttled retry adds a clamp, then the 64-step
// bit-serial remainder for the jitter.
// A refused event or a first or second ordinary retry goes from idle to S_DONE.
// Reset clears the retry count and loads the register defaults; cfg_ready is high
// whenever reset is low.
// evt_ready is low while an event is in work; a result held by a stalled res side
// keeps the sequencer in its output state until the beat can be loaded.
module retry_backoff_budget
  import rbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  evt_valid,
  output logic                  evt_ready,
  input  evt_t                  evt,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MUL_LO  = 8'b0000_0010,
    S_MUL_MID = 8'b0000_0100,
    S_MUL_HI  = 8'b0000_1000,
    S_UPD     = 8'b0001_0000,
    S_CLAMP   = 8'b0010_0000,
    S_MOD     = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration and budget state
  logic [7:0]       max_retries;
  logic [19:0]      base_wait_ms;
  logic [15:0]      backoff_factor_q8;
  logic [CNT_W-1:0] retry_count;

  // Per-event working registers
  evt_t               ev;
  logic               allowed;
  logic [CNT_W-1:0]   expo;
  logic [WAIT_W-1:0]  ip;
  logic [7:0]         fp;
  logic [31:0]        low32;
  logic [CLAMP_W-1:0] wait_cl;

  // Shared units
  mul_op_t            mul_op;
  logic [MUL_P_W-1:0] mp;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  // Budget test and clamp logic
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   count_new;
  logic [CLAMP_W-1:0] wait_capped;
  logic [3:0]         ra_c;
  logic [CLAMP_W-1:0] ra_ms;
  logic [CLAMP_W-1:0] wait_clamp;
  logic               scale_sat;
  state_t             after_scale;

  assign evt_ready = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;

  assign limit     = {1'b0, max_retries} + (evt.throttled ? EXTRA_THROTTLE_RETRIES : '0);
  assign count_new = retry_count + CNT_W'(1);

  assign wait_capped = (ip > WAIT_W'(THROTTLE_CAP_MS)) ? THROTTLE_CAP_MS : ip[CLAMP_W-1:0];
  assign ra_c        = (ev.retry_after_seconds > RA_CAP_S) ? RA_CAP_S[3:0]
                                                           : ev.retry_after_seconds[3:0];
  assign ra_ms       = CLAMP_W'(ra_c) * MS_PER_S;
  assign wait_clamp  = (ev.retry_after_valid && (ra_ms > wait_capped)) ? ra_ms : wait_capped;

  assign scale_sat   = |mp[MUL_P_W-1:31];
  assign after_scale = ev.throttled ? S_CLAMP : S_DONE;

  // Select multiplier operands for the current partial product
  always_comb begin
    mul_op = '0;
    case (state)
      S_MUL_LO: begin
        mul_op.a = {16'b0, ip[7:0], fp};
        mul_op.b = backoff_factor_q8;
      end
      S_MUL_MID: begin
        mul_op.a = ip[39:8];
        mul_op.b = backoff_factor_q8;
        mul_op.c = MUL_C_W'(mp[31:16]);
      end
      S_MUL_HI: begin
        mul_op.a = {9'b0, ip[62:40]};
        mul_op.b = backoff_factor_q8;
        mul_op.c = MUL_C_W'(mp[48:32]);
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  // Start the jitter remainder from the clamped wait
  always_comb begin
    mod_req.start    = (state == S_CLAMP);
    mod_req.dividend = ev.random_word;
    mod_req.divisor  = JIT_DIV_W'(wait_clamp >> 1) + JIT_DIV_W'(1);
  end

  rbb_mul_unit u_mul (
    .clk (clk),
    .op  (mul_op),
    .p   (mp)
  );

  rbb_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries       <= 8'd3;
      base_wait_ms      <= 20'd100;
      backoff_factor_q8 <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_RETRIES:    max_retries       <= cfg_data[7:0];
        CFG_BASE_WAIT_MS:   base_wait_ms      <= cfg_data;
        CFG_BACKOFF_FACTOR: backoff_factor_q8 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      retry_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      // Raise valid when a result is loaded, drop it once the beat is taken
      if ((state == S_DONE) && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (evt_valid) begin
            if (retry_count >= limit) begin
              state <= S_DONE;
            end else begin
              retry_count <= count_new;
              if (!evt.throttled && (count_new == CNT_W'(1))) begin
                state <= S_DONE;
              end else if (evt.throttled) begin
                state <= (count_new == CNT_W'(1)) ? S_CLAMP : S_MUL_LO;
              end else begin
                state <= (count_new == CNT_W'(2)) ? S_DONE : S_MUL_LO;
              end
            end
          end
        end
        S_MUL_LO:  state <= S_MUL_MID;
        S_MUL_MID: state <= S_MUL_HI;
        S_MUL_HI:  state <= S_UPD;
        S_UPD: begin
          if (scale_sat || (expo == CNT_W'(1))) begin
            state <= after_scale;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_CLAMP: state <= S_MOD;
        S_MOD: begin
          if (mod_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ev <= evt;
        fp <= '0;
        if (retry_count >= limit) begin
          allowed <= 1'b0;
          ip      <= '0;
        end else begin
          allowed <= 1'b1;
          ip      <= (!evt.throttled && (count_new == CNT_W'(1))) ? '0
                                                                  : WAIT_W'(base_wait_ms);
          expo    <= evt.throttled ? (count_new - CNT_W'(1)) : (count_new - CNT_W'(2));
        end
      end
      S_MUL_MID: fp    <= mp[15:8];
      S_MUL_HI:  low32 <= mp[31:0];
      S_UPD: begin
        if (scale_sat) begin
          ip <= WAIT_MAX;
        end else begin
          ip <= {mp[30:0], low32};
        end
        expo <= expo - CNT_W'(1);
      end
      S_CLAMP: wait_cl <= wait_clamp;
      S_MOD: begin
        if (mod_rsp.done) begin
          ip <= WAIT_W'(wait_cl - CLAMP_W'(mod_rsp.rem));
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          res.retry_allowed  <= allowed;
          res.wait_ms        <= ip;
          res.retries_so_far <= retry_count;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/rbb_checker.sv
// Port-level checks for the retry budget block, bound to the top level.
module rbb_checker
  import rbb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic evt_valid,
  input logic evt_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Drop ready after taking an event
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("event taken while previous event in work");

  // A refused retry carries no wait
  a_refused_zero_wait: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.retry_allowed |-> res.wait_ms == '0)
    else $error("refused retry with nonzero wait");

  // An allowed retry has used at least one retry, and the count stays in budget range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.retries_so_far <= 9'd260) &&
                  (!res.retry_allowed || (res.retries_so_far != '0)))
    else $error("retry count out of range");

endmodule

bind retry_backoff_budget rbb_checker u_rbb_checker (.*);
